@@ rtl/mhsc_pkg.sv @@
// package for the motor homing and spring controller
// holds register indexes, reset values, mode and op codes, command constants and the entry type
// depends on nothing
package mhsc_pkg;

  localparam int RegCount = 8;
  localparam int CfgW     = 15;

  localparam logic [2:0] REG_STIFFNESS = 3'd0;
  localparam logic [2:0] REG_DAMPING   = 3'd1;
  localparam logic [2:0] REG_CONTACT   = 3'd2;
  localparam logic [2:0] REG_OFFSET    = 3'd3;
  localparam logic [2:0] REG_COARSE    = 3'd4;
  localparam logic [2:0] REG_FINE      = 3'd5;
  localparam logic [2:0] REG_HOLD      = 3'd6;
  localparam logic [2:0] REG_FRICTION  = 3'd7;

  localparam logic [CfgW-1:0] CFG_RESET [RegCount] = '{
    15'd1024, 15'd77, 15'd2048, 15'd640, 15'd128, 15'd26, 15'd38, 15'd154
  };

  localparam logic [1:0] OP_FEEDBACK = 2'd0;
  localparam logic [1:0] OP_COMMAND  = 2'd1;
  localparam logic [1:0] OP_ZERO     = 2'd2;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  localparam logic [2:0] MODE_SEEK   = 3'd0;
  localparam logic [2:0] MODE_FAST   = 3'd1;
  localparam logic [2:0] MODE_SLOW   = 3'd2;
  localparam logic [2:0] MODE_HOLD   = 3'd3;
  localparam logic [2:0] MODE_SPRING = 3'd4;

  localparam logic signed [15:0] VEL_SEEK = 16'sd512;
  localparam logic signed [15:0] VEL_FAST = -16'sd640;
  localparam logic signed [15:0] VEL_SLOW = -16'sd102;
  localparam logic [14:0]        KD_SEEK  = 15'd1024;
  localparam logic [14:0]        KD_HOME  = 15'd1280;
  localparam logic [14:0]        KP_HOLD  = 15'd1280;

  typedef struct packed {
    logic [2:0]        mode;
    logic signed [15:0] pos;
    logic signed [15:0] vel;
    logic signed [15:0] trq;
    logic signed [15:0] zero;
  } entry_t;

endpackage

@@ rtl/mhsc_ram.sv @@
// generic single-write, single-read ram with registered read data
// read returns the old contents on a same-cycle write; depends on nothing
module mhsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/motor_homing_spring_controller.sv @@
// top level of the motor homing and spring controller
// depends on mhsc_pkg and mhsc_ram
//
// Takes one input word per clock unless stalled. Command slots pass stages 1 to 3 and the output
// register to out_valid_o. Per-motor state (mode, last feedback, zero) sits in one ram that is
// read on accept and written back from stage 1 as the pipeline advances. A one-entry bypass covers
// back-to-back words for the same motor. Per-motor valid bits make never-written entries read as
// zero, so there is no clearing pass after reset. The spring torque uses two multipliers in their
// own stage. The whole pipeline holds while a finished command word is stalled at the output.
module motor_homing_spring_controller #(
  parameter int MOTOR_COUNT = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          op_i,
  input  logic [1:0]          motor_i,
  input  logic signed [15:0]  position_i,
  input  logic signed [15:0]  velocity_i,
  input  logic signed [15:0]  torque_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          motor_index_o,
  output logic signed [15:0]  target_position_o,
  output logic signed [15:0]  target_velocity_o,
  output logic [14:0]         position_gain_o,
  output logic [14:0]         damping_gain_o,
  output logic signed [15:0]  feedforward_torque_o,
  output logic [2:0]          mode_o
);

  localparam int AW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int EW = $bits(mhsc_pkg::entry_t);

  // configuration registers
  logic [mhsc_pkg::CfgW-1:0] cfg_q [mhsc_pkg::RegCount];

  assign pready = 1'b1;
  assign prdata = {17'd0, cfg_q[paddr[4:2]]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= mhsc_pkg::CFG_RESET;
    end else if (psel && penable && pwrite && pready) begin
      cfg_q[paddr[4:2]] <= pwdata[mhsc_pkg::CfgW-1:0];
    end
  end

  // pipeline control
  logic en;
  logic in_take;
  logic in_keep;
  logic [AW-1:0] in_addr;

  logic out_valid_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;
  assign in_take    = in_valid_i && en;
  assign in_keep    = in_take && (32'(motor_i) < MOTOR_COUNT) && (op_i != mhsc_pkg::OP_UNUSED);
  assign in_addr    = AW'(motor_i);

  // stage 1: ram data arrives, read-modify-write
  logic                s1_valid_q;
  logic [1:0]          s1_op_q;
  logic [1:0]          s1_motor_q;
  logic [AW-1:0]       s1_addr_q;
  logic signed [15:0]  s1_pos_q;
  logic signed [15:0]  s1_vel_q;
  logic signed [15:0]  s1_trq_q;
  logic                s1_vld_q;
  logic                fwd_q;
  mhsc_pkg::entry_t    fwd_data_q;
  logic [MOTOR_COUNT-1:0] valid_q;

  logic [EW-1:0]       ram_rdata;
  mhsc_pkg::entry_t    cur;
  mhsc_pkg::entry_t    nxt;
  logic                s1_we;

  logic signed [16:0]  trq_abs;
  logic signed [16:0]  zero_diff;
  logic signed [15:0]  zero_new;
  logic [2:0]          mode_a;
  logic [2:0]          mode_b;
  logic [2:0]          mode_c;
  logic [2:0]          mode_f;
  logic signed [16:0]  dz;
  logic [16:0]         dist_abs;
  logic signed [16:0]  d_val;

  assign s1_we = s1_valid_q && en;

  mhsc_ram #(
    .WIDTH (EW),
    .DEPTH (MOTOR_COUNT)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (s1_we),
    .waddr_i (s1_addr_q),
    .wdata_i (nxt),
    .re_i    (in_keep),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      valid_q    <= '0;
      fwd_q      <= 1'b0;
      s1_vld_q   <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_keep;
      if (s1_valid_q) begin
        valid_q[s1_addr_q] <= 1'b1;
      end
      if (in_keep) begin
        fwd_q    <= s1_valid_q && (s1_addr_q == in_addr);
        s1_vld_q <= valid_q[in_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fwd_data_q <= nxt;
      if (in_keep) begin
        s1_op_q    <= op_i;
        s1_motor_q <= motor_i;
        s1_addr_q  <= in_addr;
        s1_pos_q   <= position_i;
        s1_vel_q   <= velocity_i;
        s1_trq_q   <= torque_i;
      end
    end
  end

  always_comb begin
    if (fwd_q) begin
      cur = fwd_data_q;
    end else if (s1_vld_q) begin
      cur = mhsc_pkg::entry_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  // homing checks, in order
  assign trq_abs   = cur.trq[15] ? -17'(cur.trq) : 17'(cur.trq);
  assign zero_diff = 17'(cur.pos) - $signed({2'b00, cfg_q[mhsc_pkg::REG_OFFSET]});

  always_comb begin
    mode_a   = cur.mode;
    zero_new = cur.zero;
    if ((cur.mode == mhsc_pkg::MODE_SEEK) &&
        (trq_abs > $signed({2'b00, cfg_q[mhsc_pkg::REG_CONTACT]}))) begin
      mode_a = mhsc_pkg::MODE_FAST;
      if (zero_diff[16] != zero_diff[15]) begin
        zero_new = 16'sh8000;
      end else begin
        zero_new = zero_diff[15:0];
      end
    end
  end

  assign dz       = 17'(zero_new) - 17'(cur.pos);
  assign dist_abs = dz[16] ? 17'(-dz) : 17'(dz);
  assign d_val    = -dz;

  always_comb begin
    mode_b = mode_a;
    if ((mode_a == mhsc_pkg::MODE_FAST) && (dist_abs < {2'b00, cfg_q[mhsc_pkg::REG_COARSE]})) begin
      mode_b = mhsc_pkg::MODE_SLOW;
    end
    mode_c = mode_b;
    if ((mode_b == mhsc_pkg::MODE_SLOW) && (dist_abs < {2'b00, cfg_q[mhsc_pkg::REG_FINE]})) begin
      mode_c = mhsc_pkg::MODE_HOLD;
    end
    mode_f = mode_c;
    if ((mode_c == mhsc_pkg::MODE_SPRING) &&
        (dist_abs < {2'b00, cfg_q[mhsc_pkg::REG_HOLD]})) begin
      mode_f = mhsc_pkg::MODE_HOLD;
    end else if ((mode_c == mhsc_pkg::MODE_HOLD) &&
                 (dist_abs >= {2'b00, cfg_q[mhsc_pkg::REG_HOLD]})) begin
      mode_f = mhsc_pkg::MODE_SPRING;
    end
  end

  always_comb begin
    nxt = cur;
    case (s1_op_q)
      mhsc_pkg::OP_FEEDBACK: begin
        nxt.pos = s1_pos_q;
        nxt.vel = s1_vel_q;
        nxt.trq = s1_trq_q;
      end
      mhsc_pkg::OP_ZERO: begin
        nxt.zero = s1_pos_q;
      end
      mhsc_pkg::OP_COMMAND: begin
        nxt.mode = mode_f;
        nxt.zero = zero_new;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  // stage 2: spring products
  logic                s2_valid_q;
  logic [1:0]          s2_motor_q;
  logic [2:0]          s2_mode_q;
  logic signed [15:0]  s2_zero_q;
  logic signed [16:0]  s2_d_q;
  logic signed [15:0]  s2_vel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q && (s1_op_q == mhsc_pkg::OP_COMMAND);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_motor_q <= s1_motor_q;
      s2_mode_q  <= mode_f;
      s2_zero_q  <= zero_new;
      s2_d_q     <= d_val;
      s2_vel_q   <= cur.vel;
    end
  end

  logic signed [32:0] prod_k;
  logic signed [31:0] prod_b;

  assign prod_k = s2_d_q * $signed({1'b0, cfg_q[mhsc_pkg::REG_STIFFNESS]});
  assign prod_b = $signed({1'b0, cfg_q[mhsc_pkg::REG_DAMPING]}) * s2_vel_q;

  // stage 3: sum, round, saturate, command select
  logic                s3_valid_q;
  logic [1:0]          s3_motor_q;
  logic [2:0]          s3_mode_q;
  logic signed [15:0]  s3_zero_q;
  logic                s3_dpos_q;
  logic signed [32:0]  s3_pk_q;
  logic signed [31:0]  s3_pb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_motor_q <= s2_motor_q;
      s3_mode_q  <= s2_mode_q;
      s3_zero_q  <= s2_zero_q;
      s3_dpos_q  <= !s2_d_q[16] && (s2_d_q != 17'sd0);
      s3_pk_q    <= prod_k;
      s3_pb_q    <= prod_b;
    end
  end

  logic signed [34:0] fric;
  logic signed [34:0] acc;
  logic signed [26:0] rnd;
  logic signed [15:0] spring;

  assign fric = $signed({12'd0, cfg_q[mhsc_pkg::REG_FRICTION], 8'd0});
  assign acc  = -35'(s3_pk_q) - 35'(s3_pb_q) + (s3_dpos_q ? -fric : fric) + 35'sd128;
  assign rnd  = 27'(acc >>> 8);

  always_comb begin
    if (rnd > 27'sd32767) begin
      spring = 16'sh7fff;
    end else if (rnd < -27'sd32768) begin
      spring = 16'sh8000;
    end else begin
      spring = rnd[15:0];
    end
  end

  logic signed [15:0] cmd_pos;
  logic signed [15:0] cmd_vel;
  logic [14:0]        cmd_kp;
  logic [14:0]        cmd_kd;
  logic signed [15:0] cmd_trq;

  always_comb begin
    cmd_pos = '0;
    cmd_vel = '0;
    cmd_kp  = '0;
    cmd_kd  = '0;
    cmd_trq = '0;
    case (s3_mode_q)
      mhsc_pkg::MODE_SEEK: begin
        cmd_vel = mhsc_pkg::VEL_SEEK;
        cmd_kd  = mhsc_pkg::KD_SEEK;
      end
      mhsc_pkg::MODE_FAST: begin
        cmd_vel = mhsc_pkg::VEL_FAST;
        cmd_kd  = mhsc_pkg::KD_HOME;
      end
      mhsc_pkg::MODE_SLOW: begin
        cmd_pos = s3_zero_q;
        cmd_vel = mhsc_pkg::VEL_SLOW;
        cmd_kd  = mhsc_pkg::KD_HOME;
      end
      mhsc_pkg::MODE_HOLD: begin
        cmd_pos = s3_zero_q;
        cmd_kp  = mhsc_pkg::KP_HOLD;
      end
      mhsc_pkg::MODE_SPRING: begin
        cmd_trq = spring;
      end
      default: begin
        cmd_pos = '0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      motor_index_o        <= s3_motor_q;
      target_position_o    <= cmd_pos;
      target_velocity_o    <= cmd_vel;
      position_gain_o      <= cmd_kp;
      damping_gain_o       <= cmd_kd;
      feedforward_torque_o <= cmd_trq;
      mode_o               <= s3_mode_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
